// ===== sv/axisymmetric_llg_rhs_stencil_core_defines.svh =====
// Assertion macros shared by the stencil core modules.
`ifndef AXISYMMETRIC_LLG_RHS_STENCIL_CORE_DEFINES_SVH
`define AXISYMMETRIC_LLG_RHS_STENCIL_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define ALLG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define ALLG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/allg_pkg.sv =====
// Shared types, constants and the field-update microprogram of the stencil core.
`default_nettype none

package allg_pkg;

	localparam int MaxColumns    = 512;
	localparam int MaxRows       = 256;
	localparam int ColW          = $clog2(MaxColumns);
	localparam int RowW          = $clog2(MaxRows);
	localparam int NcolW         = ColW + 1;
	localparam int NrowW         = RowW + 1;
	localparam int RowStoreDepth = 2 * MaxColumns;
	localparam int RowAddrW      = $clog2(RowStoreDepth);

	typedef logic signed [63:0] word_t;

	// one grid point, m_x in the low bits
	typedef struct packed {
		logic [31:0]        ir;
		logic signed [31:0] mz;
		logic signed [31:0] my;
		logic signed [31:0] mx;
	} point_t;

	typedef struct packed {
		logic signed [31:0] dmi;
		logic signed [31:0] dp;
		logic signed [31:0] an;
		logic [31:0]        h1;
		logic [31:0]        h2;
		logic [31:0]        z2;
	} coef_t;

	// five-point neighborhood plus the position of the result point
	typedef struct packed {
		point_t            up;
		point_t            left;
		point_t            ctr;
		point_t            right;
		point_t            down;
		logic [ColW-1:0]   col;
		logic [RowW-1:0]   row;
		logic              last;
	} job_t;

	typedef struct packed {
		logic signed [47:0] dm_x;
		logic signed [47:0] dm_y;
		logic signed [47:0] dm_z;
		logic [ColW-1:0]    col;
		logic [RowW-1:0]    row;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL16 = 3'd2,
		OP_MUL15 = 3'd3,
		OP_MUL30 = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		SH16 = 2'd0,
		SH15 = 2'd1,
		SH30 = 2'd2
	} shift_t;

	typedef logic [5:0] src_t;

	localparam int SlotCount = 16;
	localparam int SlotW     = $clog2(SlotCount);

	// scratch slots
	localparam src_t S_T0   = 6'd0;
	localparam src_t S_T1   = 6'd1;
	localparam src_t S_T2   = 6'd2;
	localparam src_t S_D1X  = 6'd3;
	localparam src_t S_D1Y  = 6'd4;
	localparam src_t S_D1Z  = 6'd5;
	localparam src_t S_F0   = 6'd6;
	localparam src_t S_F1   = 6'd7;
	localparam src_t S_F2   = 6'd8;
	localparam src_t S_CR0  = 6'd9;
	localparam src_t S_CR1  = 6'd10;
	localparam src_t S_CR2  = 6'd11;
	localparam src_t S_DOT  = 6'd12;
	localparam src_t S_OUT0 = 6'd13;
	localparam src_t S_OUT1 = 6'd14;
	localparam src_t S_OUT2 = 6'd15;
	// fixed operands: neighborhood, coefficients, zero
	localparam src_t S_UX   = 6'd16;
	localparam src_t S_UY   = 6'd17;
	localparam src_t S_UZ   = 6'd18;
	localparam src_t S_LX   = 6'd19;
	localparam src_t S_LY   = 6'd20;
	localparam src_t S_LZ   = 6'd21;
	localparam src_t S_CX   = 6'd22;
	localparam src_t S_CY   = 6'd23;
	localparam src_t S_CZ   = 6'd24;
	localparam src_t S_RX   = 6'd25;
	localparam src_t S_RY   = 6'd26;
	localparam src_t S_RZ   = 6'd27;
	localparam src_t S_DX   = 6'd28;
	localparam src_t S_DY   = 6'd29;
	localparam src_t S_DZ   = 6'd30;
	localparam src_t S_IR   = 6'd31;
	localparam src_t S_DMI  = 6'd32;
	localparam src_t S_DP   = 6'd33;
	localparam src_t S_AN   = 6'd34;
	localparam src_t S_H1   = 6'd35;
	localparam src_t S_H2   = 6'd36;
	localparam src_t S_Z2   = 6'd37;
	localparam src_t S_ZERO = 6'd38;

	typedef struct packed {
		op_t  op;
		src_t a;
		src_t b;
		src_t dst;
	} instr_t;

	localparam int ProgLen = 79;
	localparam int PcW     = $clog2(ProgLen);

	function automatic instr_t mk(op_t op, src_t a, src_t b, src_t dst);
		instr_t i;
		i.op  = op;
		i.a   = a;
		i.b   = b;
		i.dst = dst;
		return i;
	endfunction

	// effective field, then dm = -(m x f) - dp*((m.f)m - f)
	function automatic instr_t prog(logic [PcW-1:0] pc);
		instr_t i;
		case (pc)
			// radial component
			7'd0:  i = mk(OP_ADD,   S_RX,  S_LX,  S_T0);
			7'd1:  i = mk(OP_ADD,   S_CX,  S_CX,  S_T1);
			7'd2:  i = mk(OP_SUB,   S_T0,  S_T1,  S_T0);
			7'd3:  i = mk(OP_MUL16, S_T0,  S_H2,  S_T0);
			7'd4:  i = mk(OP_ADD,   S_UX,  S_DX,  S_T2);
			7'd5:  i = mk(OP_SUB,   S_T2,  S_T1,  S_T2);
			7'd6:  i = mk(OP_MUL16, S_T2,  S_Z2,  S_T2);
			7'd7:  i = mk(OP_SUB,   S_RX,  S_LX,  S_D1X);
			7'd8:  i = mk(OP_MUL16, S_D1X, S_H1,  S_D1X);
			7'd9:  i = mk(OP_MUL16, S_D1X, S_IR,  S_T1);
			7'd10: i = mk(OP_ADD,   S_T0,  S_T1,  S_F0);
			7'd11: i = mk(OP_ADD,   S_F0,  S_T2,  S_F0);
			7'd12: i = mk(OP_MUL16, S_CX,  S_IR,  S_T0);
			7'd13: i = mk(OP_MUL16, S_T0,  S_IR,  S_T0);
			7'd14: i = mk(OP_SUB,   S_F0,  S_T0,  S_F0);
			// azimuthal component
			7'd15: i = mk(OP_ADD,   S_RY,  S_LY,  S_T0);
			7'd16: i = mk(OP_ADD,   S_CY,  S_CY,  S_T1);
			7'd17: i = mk(OP_SUB,   S_T0,  S_T1,  S_T0);
			7'd18: i = mk(OP_MUL16, S_T0,  S_H2,  S_T0);
			7'd19: i = mk(OP_ADD,   S_UY,  S_DY,  S_T2);
			7'd20: i = mk(OP_SUB,   S_T2,  S_T1,  S_T2);
			7'd21: i = mk(OP_MUL16, S_T2,  S_Z2,  S_T2);
			7'd22: i = mk(OP_SUB,   S_RY,  S_LY,  S_D1Y);
			7'd23: i = mk(OP_MUL16, S_D1Y, S_H1,  S_D1Y);
			7'd24: i = mk(OP_MUL16, S_D1Y, S_IR,  S_T1);
			7'd25: i = mk(OP_ADD,   S_T0,  S_T1,  S_F1);
			7'd26: i = mk(OP_ADD,   S_F1,  S_T2,  S_F1);
			7'd27: i = mk(OP_MUL16, S_CY,  S_IR,  S_T0);
			7'd28: i = mk(OP_MUL16, S_T0,  S_IR,  S_T0);
			7'd29: i = mk(OP_SUB,   S_F1,  S_T0,  S_F1);
			// axial component, no 1/r^2 term
			7'd30: i = mk(OP_ADD,   S_RZ,  S_LZ,  S_T0);
			7'd31: i = mk(OP_ADD,   S_CZ,  S_CZ,  S_T1);
			7'd32: i = mk(OP_SUB,   S_T0,  S_T1,  S_T0);
			7'd33: i = mk(OP_MUL16, S_T0,  S_H2,  S_T0);
			7'd34: i = mk(OP_ADD,   S_UZ,  S_DZ,  S_T2);
			7'd35: i = mk(OP_SUB,   S_T2,  S_T1,  S_T2);
			7'd36: i = mk(OP_MUL16, S_T2,  S_Z2,  S_T2);
			7'd37: i = mk(OP_SUB,   S_RZ,  S_LZ,  S_D1Z);
			7'd38: i = mk(OP_MUL16, S_D1Z, S_H1,  S_D1Z);
			7'd39: i = mk(OP_MUL16, S_D1Z, S_IR,  S_T1);
			7'd40: i = mk(OP_ADD,   S_T0,  S_T1,  S_F2);
			7'd41: i = mk(OP_ADD,   S_F2,  S_T2,  S_F2);
			// DMI and anisotropy
			7'd42: i = mk(OP_MUL15, S_D1Z, S_DMI, S_T0);
			7'd43: i = mk(OP_ADD,   S_F1,  S_T0,  S_F1);
			7'd44: i = mk(OP_MUL16, S_CY,  S_IR,  S_T0);
			7'd45: i = mk(OP_ADD,   S_D1Y, S_T0,  S_T0);
			7'd46: i = mk(OP_MUL15, S_T0,  S_DMI, S_T0);
			7'd47: i = mk(OP_SUB,   S_F2,  S_T0,  S_F2);
			7'd48: i = mk(OP_MUL16, S_CZ,  S_AN,  S_T0);
			7'd49: i = mk(OP_ADD,   S_F2,  S_T0,  S_F2);
			// cross product m x f
			7'd50: i = mk(OP_MUL30, S_CY,  S_F2,  S_T0);
			7'd51: i = mk(OP_MUL30, S_CZ,  S_F1,  S_T1);
			7'd52: i = mk(OP_SUB,   S_T0,  S_T1,  S_CR0);
			7'd53: i = mk(OP_MUL30, S_CZ,  S_F0,  S_T0);
			7'd54: i = mk(OP_MUL30, S_CX,  S_F2,  S_T1);
			7'd55: i = mk(OP_SUB,   S_T0,  S_T1,  S_CR1);
			7'd56: i = mk(OP_MUL30, S_CX,  S_F1,  S_T0);
			7'd57: i = mk(OP_MUL30, S_CY,  S_F0,  S_T1);
			7'd58: i = mk(OP_SUB,   S_T0,  S_T1,  S_CR2);
			// dot product m . f
			7'd59: i = mk(OP_MUL30, S_CX,  S_F0,  S_T0);
			7'd60: i = mk(OP_MUL30, S_CY,  S_F1,  S_T1);
			7'd61: i = mk(OP_ADD,   S_T0,  S_T1,  S_DOT);
			7'd62: i = mk(OP_MUL30, S_CZ,  S_F2,  S_T1);
			7'd63: i = mk(OP_ADD,   S_DOT, S_T1,  S_DOT);
			// damping and final sum per component
			7'd64: i = mk(OP_MUL30, S_DOT, S_CX,  S_T0);
			7'd65: i = mk(OP_SUB,   S_T0,  S_F0,  S_T0);
			7'd66: i = mk(OP_MUL16, S_T0,  S_DP,  S_T0);
			7'd67: i = mk(OP_SUB,   S_ZERO, S_CR0, S_T1);
			7'd68: i = mk(OP_SUB,   S_T1,  S_T0,  S_OUT0);
			7'd69: i = mk(OP_MUL30, S_DOT, S_CY,  S_T0);
			7'd70: i = mk(OP_SUB,   S_T0,  S_F1,  S_T0);
			7'd71: i = mk(OP_MUL16, S_T0,  S_DP,  S_T0);
			7'd72: i = mk(OP_SUB,   S_ZERO, S_CR1, S_T1);
			7'd73: i = mk(OP_SUB,   S_T1,  S_T0,  S_OUT1);
			7'd74: i = mk(OP_MUL30, S_DOT, S_CZ,  S_T0);
			7'd75: i = mk(OP_SUB,   S_T0,  S_F2,  S_T0);
			7'd76: i = mk(OP_MUL16, S_T0,  S_DP,  S_T0);
			7'd77: i = mk(OP_SUB,   S_ZERO, S_CR2, S_T1);
			7'd78: i = mk(OP_SUB,   S_T1,  S_T0,  S_OUT2);
			default: i = mk(OP_ADD, S_ZERO, S_ZERO, S_T0);
		endcase
		return i;
	endfunction

endpackage

`default_nettype wire

// ===== sv/axisymmetric_llg_rhs_stencil_core.sv =====
// Top level of the axisymmetric LLG right-hand-side stencil core.
//
//  channel | dir | beat contents (low bit first)                        | handshake
//  s_axis  | in  | tdata m_x, m_y, m_z, inv_r; tuser frame_start         | tvalid/tready
//  m_axis  | out | tdata dm_x, dm_y, dm_z, col_index, row_index; tlast  | tvalid/tready
//  cfg     | in  | cfg_index selects register, cfg_data value           | cfg_we
//
// A boundary point is only stored in the row store, and the counters advance.
// An interior point first does the four row-store reads and the write, then runs
// 79 micro-ops, where each of the 35 multiplies goes to the one shared serial 64x64
// multiplier and each add or subtract goes through the saturating adder.
// A finished result waits in the output register; the next beat is taken meanwhile.
// Reset clears counters and control and loads the configuration registers with defaults;
// the row store keeps no reset and is valid once a frame has filled two rows.
`default_nettype none

module axisymmetric_llg_rhs_stencil_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,   // m_x, m_y, m_z, inv_r
	input  wire logic         s_axis_tuser,   // frame_start
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [167:0]      m_axis_tdata,   // dm_x, dm_y, dm_z, col_index, row_index, pad
	output logic              m_axis_tlast,   // frame_last
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import allg_pkg::*;

	localparam logic [2:0] REG_DMI  = 3'd0;
	localparam logic [2:0] REG_DP   = 3'd1;
	localparam logic [2:0] REG_AN   = 3'd2;
	localparam logic [2:0] REG_H1   = 3'd3;
	localparam logic [2:0] REG_H2   = 3'd4;
	localparam logic [2:0] REG_Z2   = 3'd5;
	localparam logic [2:0] REG_COLS = 3'd6;
	localparam logic [2:0] REG_ROWS = 3'd7;

	coef_t             coef_q;
	logic [NcolW-1:0]  cols_q;
	logic [NrowW-1:0]  rows_q;
	result_t           out_q;
	logic              out_valid_q;

	logic              in_accept;
	logic              fetch_idle;
	logic              eng_start;
	job_t              job;
	logic              eng_busy;
	logic              res_valid;
	logic              res_take;
	result_t           res;

	// the user is to change registers only while idle (not enforced here), so no shadowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.dmi <= 32'sd41288;
			coef_q.dp  <= 32'sd328;
			coef_q.an  <= 32'sd65536;
			coef_q.h1  <= 32'd32768;
			coef_q.h2  <= 32'd65536;
			coef_q.z2  <= 32'd65536;
			cols_q     <= NcolW'(MaxColumns);
			rows_q     <= NrowW'(MaxRows);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DMI:  coef_q.dmi <= cfg_data;
				REG_DP:   coef_q.dp  <= cfg_data;
				REG_AN:   coef_q.an  <= cfg_data;
				REG_H1:   coef_q.h1  <= cfg_data;
				REG_H2:   coef_q.h2  <= cfg_data;
				REG_Z2:   coef_q.z2  <= cfg_data;
				REG_COLS: cols_q     <= cfg_data[NcolW-1:0];
				REG_ROWS: rows_q     <= cfg_data[NrowW-1:0];
				default:  ;
			endcase
		end
	end

	// one point in flight; the output register decouples the result side.
	// Hold off in the cycle the engine is being started, since the job still
	// reads the fetch registers.
	assign s_axis_tready = fetch_idle && !eng_busy && !eng_start;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	allg_stencil_fetch u_fetch (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_accept),
		.frame_start    (s_axis_tuser),
		.point          (point_t'(s_axis_tdata)),
		.columns_in_use (cols_q),
		.rows_in_use    (rows_q),
		.idle           (fetch_idle),
		.start          (eng_start),
		.job            (job)
	);

	allg_rhs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (eng_start),
		.job       (job),
		.coef      (coef_q),
		.busy      (eng_busy),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// load a new result when the slot is empty or drains this cycle
	assign res_take = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk) begin
		if (res_take)
			out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_take)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.row, out_q.col, out_q.dm_z, out_q.dm_y, out_q.dm_x};
	assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire

// ===== sv/allg_stencil_fetch.sv =====
// Position counters, two-row store and the five-point neighborhood registers.
`default_nettype none
`include "axisymmetric_llg_rhs_stencil_core_defines.svh"

module allg_stencil_fetch (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          frame_start,
	input  wire allg_pkg::point_t              point,
	input  wire logic [allg_pkg::NcolW-1:0]    columns_in_use,
	input  wire logic [allg_pkg::NrowW-1:0]    rows_in_use,
	output logic                               idle,
	output logic                               start,
	output allg_pkg::job_t                     job
);
	import allg_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE  = 4'b0001,
		F_READ  = 4'b0010,
		F_DRAIN = 4'b0100,
		F_WRITE = 4'b1000
	} fstate_t;

	fstate_t             state_q;
	logic [ColW-1:0]     col_q, c_q;
	logic [RowW-1:0]     row_q, r_q;
	logic                last_q;
	point_t              cur_q;
	point_t              win_q [4];
	logic [1:0]          rd_cnt_q;
	logic                rd_vld_s1;
	logic [1:0]          rd_sel_s1;
	logic [127:0]        rd_data_q;
	logic [127:0]        mem [RowStoreDepth];

	logic [NcolW-1:0]    ncol;
	logic [NrowW-1:0]    nrow;
	logic [ColW-1:0]     c_in;
	logic [RowW-1:0]     r_in;
	logic                interior;
	logic                rd_en;
	logic [RowAddrW-1:0] rd_addr;
	logic                we;
	logic [NcolW-1:0]    c_next;
	logic [NrowW-1:0]    r_next;

	always_comb begin
		if (columns_in_use < NcolW'(3))
			ncol = NcolW'(3);
		else if (columns_in_use > NcolW'(MaxColumns))
			ncol = NcolW'(MaxColumns);
		else
			ncol = columns_in_use;
		if (rows_in_use < NrowW'(3))
			nrow = NrowW'(3);
		else if (rows_in_use > NrowW'(MaxRows))
			nrow = NrowW'(MaxRows);
		else
			nrow = rows_in_use;
	end

	assign c_in = frame_start ? '0 : col_q;
	assign r_in = frame_start ? '0 : row_q;
	assign interior = ({1'b0, r_in} >= NrowW'(2)) && ({1'b0, r_in} <= nrow - NrowW'(1)) &&
		({1'b0, c_in} >= NcolW'(1)) && ({1'b0, c_in} <= ncol - NcolW'(2));

	// above row shares the parity of the arriving row
	always_comb begin
		case (rd_cnt_q)
			2'd0:    rd_addr = {r_q[0], c_q};
			2'd1:    rd_addr = {~r_q[0], c_q - ColW'(1)};
			2'd2:    rd_addr = {~r_q[0], c_q};
			default: rd_addr = {~r_q[0], c_q + ColW'(1)};
		endcase
	end

	assign rd_en  = (state_q == F_READ);
	assign we     = (state_q == F_WRITE);
	assign c_next = {1'b0, c_q} + NcolW'(1);
	assign r_next = {1'b0, r_q} + NrowW'(1);

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
		if (we)
			mem[{r_q[0], c_q}] <= cur_q;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= point;
			c_q    <= c_in;
			r_q    <= r_in;
			last_q <= ({1'b0, r_in} == nrow - NrowW'(1)) &&
				({1'b0, c_in} == ncol - NcolW'(2));
		end
		if (rd_vld_s1)
			win_q[rd_sel_s1] <= rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			rd_sel_s1 <= '0;
			start     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			rd_sel_s1 <= rd_cnt_q;
			start     <= 1'b0;
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						state_q  <= interior ? F_READ : F_WRITE;
					end
				end
				F_READ: begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3)
						state_q <= F_DRAIN;
				end
				F_DRAIN: begin
					state_q <= F_WRITE;
				end
				F_WRITE: begin
					// only interior points read the store
					start <= ({1'b0, r_q} >= NrowW'(2)) &&
						({1'b0, r_q} <= nrow - NrowW'(1)) &&
						({1'b0, c_q} >= NcolW'(1)) && ({1'b0, c_q} <= ncol - NcolW'(2));
					if (c_next >= ncol) begin
						col_q <= '0;
						row_q <= (r_next >= nrow) ? '0 : r_next[RowW-1:0];
					end else begin
						col_q <= c_next[ColW-1:0];
						row_q <= r_q;
					end
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign idle = (state_q == F_IDLE);

	always_comb begin
		job.up    = win_q[0];
		job.left  = win_q[1];
		job.ctr   = win_q[2];
		job.right = win_q[3];
		job.down  = cur_q;
		job.col   = c_q;
		job.row   = r_q - RowW'(1);
		job.last  = last_q;
	end

	`ALLG_ASSERT_NOW(a_fetch_no_rw_overlap, we, !rd_en && !rd_vld_s1, "row store written while reading")
	`ALLG_ASSERT_NEXT(a_fetch_start_idle, start, state_q == F_IDLE, "start issued outside idle")

endmodule

`default_nettype wire

// ===== sv/allg_mulsh_unit.sv =====
// Serial 64x64 signed multiply with floor shift and saturation, one 32x32 product a cycle.
`default_nettype none

module allg_mulsh_unit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire allg_pkg::word_t a,
	input  wire allg_pkg::word_t b,
	input  wire allg_pkg::shift_t sh,
	output logic                 done,
	output allg_pkg::word_t      prod
);
	import allg_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE  = 4'b0001,
		M_ACC   = 4'b0010,
		M_ROUND = 4'b0100,
		M_SAT   = 4'b1000
	} mstate_t;

	mstate_t       state_q;
	logic [63:0]   ua_q, ub_q;
	logic          neg_q;
	shift_t        sh_q;
	logic [1:0]    step_q;
	logic [127:0]  acc_q;
	logic [63:0]   q_q;
	logic          over_q;

	logic [31:0]   ah, bh;
	logic [63:0]   pp;
	logic [127:0]  pp_sh;
	logic [127:0]  shifted;
	logic          rem_nz;
	logic [127:0]  q_full;

	assign ah = step_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign bh = step_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign pp = ah * bh;

	always_comb begin
		case (step_q)
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
	end

	always_comb begin
		case (sh_q)
			SH15: begin
				shifted = acc_q >> 15;
				rem_nz  = |acc_q[14:0];
			end
			SH30: begin
				shifted = acc_q >> 30;
				rem_nz  = |acc_q[29:0];
			end
			default: begin
				shifted = acc_q >> 16;
				rem_nz  = |acc_q[15:0];
			end
		endcase
		// floor of a negative product rounds the magnitude up
		q_full = shifted + {127'd0, neg_q & rem_nz};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				ua_q  <= a[63] ? 64'(-a) : 64'(a);
				ub_q  <= b[63] ? 64'(-b) : 64'(b);
				neg_q <= a[63] ^ b[63];
				sh_q  <= sh;
				acc_q <= '0;
			end
			M_ACC: acc_q <= acc_q + pp_sh;
			M_ROUND: begin
				q_q    <= q_full[63:0];
				over_q <= |q_full[127:64];
			end
			M_SAT: begin
				if (neg_q)
					prod <= (over_q || q_q[63]) ? {1'b1, 63'd0} : -$signed(q_q);
				else
					prod <= (over_q || q_q[63]) ? {1'b0, {63{1'b1}}} : $signed(q_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			step_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				M_IDLE: begin
					step_q <= '0;
					if (start)
						state_q <= M_ACC;
				end
				M_ACC: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3)
						state_q <= M_ROUND;
				end
				M_ROUND: state_q <= M_SAT;
				M_SAT: begin
					done    <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/allg_rhs_engine.sv =====
// Microprogrammed field and dm evaluation over a two-read scratch memory.
`default_nettype none
`include "axisymmetric_llg_rhs_stencil_core_defines.svh"

module allg_rhs_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire allg_pkg::job_t    job,
	input  wire allg_pkg::coef_t   coef,
	output logic                   busy,
	output logic                   res_valid,
	input  wire logic              res_take,
	output allg_pkg::result_t      res
);
	import allg_pkg::*;

	typedef enum logic [4:0] {
		E_IDLE  = 5'b00001,
		E_FETCH = 5'b00010,
		E_EXEC  = 5'b00100,
		E_MUL   = 5'b01000,
		E_HOLD  = 5'b10000
	} estate_t;

	estate_t          state_q;
	logic [PcW-1:0]   pc_q;
	word_t            rd_a_q, rd_b_q;
	word_t            scr [SlotCount];
	logic signed [47:0] dmx_q, dmy_q, dmz_q;

	instr_t           ins;
	word_t            opa, opb;
	logic             is_mul;
	shift_t           msh;
	logic             mul_start;
	logic             mul_done;
	word_t            mul_prod;
	word_t            alu;
	logic             wb_en;
	word_t            wb_val;
	logic             advance;

	function automatic word_t fixed_op(src_t code, job_t j, coef_t c);
		word_t v;
		case (code)
			S_UX:    v = 64'(j.up.mx);
			S_UY:    v = 64'(j.up.my);
			S_UZ:    v = 64'(j.up.mz);
			S_LX:    v = 64'(j.left.mx);
			S_LY:    v = 64'(j.left.my);
			S_LZ:    v = 64'(j.left.mz);
			S_CX:    v = 64'(j.ctr.mx);
			S_CY:    v = 64'(j.ctr.my);
			S_CZ:    v = 64'(j.ctr.mz);
			S_RX:    v = 64'(j.right.mx);
			S_RY:    v = 64'(j.right.my);
			S_RZ:    v = 64'(j.right.mz);
			S_DX:    v = 64'(j.down.mx);
			S_DY:    v = 64'(j.down.my);
			S_DZ:    v = 64'(j.down.mz);
			S_IR:    v = {32'd0, j.ctr.ir};
			S_DMI:   v = 64'(c.dmi);
			S_DP:    v = 64'(c.dp);
			S_AN:    v = 64'(c.an);
			S_H1:    v = {32'd0, c.h1};
			S_H2:    v = {32'd0, c.h2};
			S_Z2:    v = {32'd0, c.z2};
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic word_t sat_sum(word_t x, word_t y, logic sub);
		logic signed [64:0] s;
		s = sub ? ({x[63], x} - {y[63], y}) : ({x[63], x} + {y[63], y});
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [47:0] sat48(word_t v);
		if (v[63:47] != {17{v[63]}})
			return v[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		return v[47:0];
	endfunction

	assign ins = prog(pc_q);
	assign opa = (ins.a < src_t'(SlotCount)) ? rd_a_q : fixed_op(ins.a, job, coef);
	assign opb = (ins.b < src_t'(SlotCount)) ? rd_b_q : fixed_op(ins.b, job, coef);

	always_comb begin
		is_mul = 1'b1;
		msh    = SH16;
		case (ins.op)
			OP_MUL15: msh = SH15;
			OP_MUL30: msh = SH30;
			OP_MUL16: msh = SH16;
			default:  is_mul = 1'b0;
		endcase
	end

	assign alu       = sat_sum(opa, opb, ins.op == OP_SUB);
	assign mul_start = (state_q == E_EXEC) && is_mul;
	assign wb_en     = ((state_q == E_EXEC) && !is_mul) || ((state_q == E_MUL) && mul_done);
	assign wb_val    = (state_q == E_MUL) ? mul_prod : alu;
	assign advance   = wb_en;

	allg_mulsh_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (opa),
		.b      (opb),
		.sh     (msh),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// one instruction at a time: a write lands before the next read is issued
	always_ff @(posedge clk) begin
		if (wb_en)
			scr[ins.dst[SlotW-1:0]] <= wb_val;
		if (state_q == E_FETCH) begin
			rd_a_q <= scr[ins.a[SlotW-1:0]];
			rd_b_q <= scr[ins.b[SlotW-1:0]];
		end
		if (wb_en) begin
			case (ins.dst)
				S_OUT0:  dmx_q <= sat48(wb_val);
				S_OUT1:  dmy_q <= sat48(wb_val);
				S_OUT2:  dmz_q <= sat48(wb_val);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			pc_q    <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					pc_q <= '0;
					if (start)
						state_q <= E_FETCH;
				end
				E_FETCH: state_q <= E_EXEC;
				E_EXEC, E_MUL: begin
					if (is_mul && state_q == E_EXEC)
						state_q <= E_MUL;
					else if (advance) begin
						if (pc_q == PcW'(ProgLen - 1))
							state_q <= E_HOLD;
						else begin
							pc_q    <= pc_q + PcW'(1);
							state_q <= E_FETCH;
						end
					end
				end
				E_HOLD: begin
					if (res_take)
						state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != E_IDLE);
	assign res_valid = (state_q == E_HOLD);

	always_comb begin
		res.dm_x = dmx_q;
		res.dm_y = dmy_q;
		res.dm_z = dmz_q;
		res.col  = job.col;
		res.row  = job.row;
		res.last = job.last;
	end

	`ALLG_ASSERT_NOW(a_eng_start_idle, start, state_q == E_IDLE, "engine started while busy")
	`ALLG_ASSERT_NOW(a_eng_mul_done, mul_done, state_q == E_MUL, "multiplier result with no waiter")

endmodule

`default_nettype wire
